>>> design/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types and constants of the Modbus RTU read-input-registers slave.
// ----------------------------------------------------------------------------
package mbrtu_pkg;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  FUNC_READ_INPUT = 8'd4;
	localparam int unsigned HDR_LEN = 6;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_CRC   = 3'd2;
	localparam logic [2:0] ST_ADDR  = 3'd3;
	localparam logic [2:0] ST_FUNC  = 3'd4;
	localparam logic [2:0] ST_RANGE = 3'd5;

	localparam logic OP_RX_BYTE = 1'b0;
	localparam logic OP_WRITE   = 1'b1;

	// request to the shared CRC unit
	typedef struct packed {
		logic        load;
		logic        init;
		logic [7:0]  data;
	} crc_req_t;

	typedef struct packed {
		logic        busy;
		logic [15:0] crc;
	} crc_rsp_t;
endpackage

>>> design/mbrtu_crc.sv
// ----------------------------------------------------------------------------
// mbrtu_crc
// Bit-serial CRC-16 unit: one shift per cycle, eight shifts per byte.
// ----------------------------------------------------------------------------
module mbrtu_crc import mbrtu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  crc_req_t req,
	output crc_rsp_t rsp
);
	logic [15:0] crc_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic [15:0] start;

	assign start = (req.init ? CRC_INIT : crc_q) ^ {8'h00, req.data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			cnt_q  <= 3'd0;
			busy_q <= 1'b0;
		end else if (req.load) begin
			crc_q  <= start;
			cnt_q  <= 3'd0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q  <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
			cnt_q  <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) busy_q <= 1'b0;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.crc  = crc_q;
endmodule

>>> design/modbus_rtu_read_input_slave.sv
// ----------------------------------------------------------------------------
// modbus_rtu_read_input_slave
// Modbus RTU slave answering Read Input Registers (function 4).
// ----------------------------------------------------------------------------
// Input beats on s_axis: operation selects a received frame byte or a
// register write. Frame bytes fold into a running CRC-16 two bytes behind.
// On the beat marked last the frame is checked; a good function-4 request
// is answered on m_axis byte by byte (id, 4, count, registers MSB first,
// CRC low, CRC high), anything else gives one status beat with tlast set.
// A register write leaves the block idle. A frame byte holds ready low
// until the bit-serial CRC unit is done, save the first two bytes of a
// frame. Each reply byte waits for the CRC unit; a next register is
// fetched through the registered read port, and the two CRC bytes go
// out from the held CRC, all plus the wait for the receiver.
// s_axis_tready is low while an item or its reply is in work, so a
// stalled receiver holds the block. Reset returns the frame state,
// slave_id = 1, and runs a clearing pass over the register bank before
// the first item is taken. cfg_valid/cfg_ready write slave_id; the user
// does so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module modbus_rtu_read_input_slave import mbrtu_pkg::*; #(
	parameter int REG_COUNT = 64,
	parameter int MAX_READ  = 29
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // rx_byte[7:0], reg_index[13:8], reg_value[29:14]
	input  logic        s_axis_tlast,  // frame_end
	input  logic        s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // tx_byte
	output logic        m_axis_tlast,  // tx_last
	output logic [2:0]  m_axis_tuser,  // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_CRCW = 3'd2, S_CHK = 3'd3,
		S_RD = 3'd4, S_BYTE = 3'd5, S_OUT = 3'd6, S_WAIT = 3'd7;

	logic [2:0]  st_q;
	logic [7:0]  id_q, cnt_q;
	logic [7:0]  hdr_q [HDR_LEN];
	logic [15:0] tail_q, fcrc_q, vword_q;
	logic [8:0]  clr_q;
	logic [5:0]  ridx_q;      // reply byte index
	logic [4:0]  qleft_q;
	logic [8:0]  addr_q;
	logic        lo_q, crcphase_q;
	logic [15:0] mem [REG_COUNT];
	logic [15:0] rd_q;
	crc_req_t    creq;
	crc_rsp_t    crsp;
	logic [7:0]  obyte_q;
	logic        olast_q;
	logic [2:0]  ostat_q;
	logic        ovalid_q;

	mbrtu_crc u_crc (.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp));

	logic        acc;
	logic        is_wr;
	logic [7:0]  rxb;
	logic [5:0]  widx;
	logic [8:0]  waddr;
	logic [15:0] start, qty;
	logic [16:0] endp;
	logic [7:0]  nb;

	assign acc   = s_axis_tvalid && s_axis_tready;
	assign is_wr = s_axis_tuser == OP_WRITE;
	assign rxb   = s_axis_tdata[7:0];
	assign widx  = s_axis_tdata[13:8];
	assign waddr = {3'b000, widx};
	assign start = {hdr_q[2], hdr_q[3]};
	assign qty   = {hdr_q[4], hdr_q[5]};
	assign endp  = {1'b0, start} + {1'b0, qty};
	assign s_axis_tready = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (st_q == S_CLR)
			mem[clr_q[AW-1:0]] <= 16'h0000;
		else if (acc && is_wr && waddr < 9'(REG_COUNT))
			mem[waddr[AW-1:0]] <= s_axis_tdata[29:14];
		rd_q <= mem[addr_q[AW-1:0]];
	end

	// next reply byte from its index
	always_comb begin
		unique case (ridx_q)
			6'd0:    nb = id_q;
			6'd1:    nb = FUNC_READ_INPUT;
			6'd2:    nb = {2'b00, qleft_q, 1'b0};
			default: nb = lo_q ? vword_q[7:0] : vword_q[15:8];
		endcase
	end

	always_comb begin
		creq = '0;
		if (acc && !is_wr && cnt_q >= 8'd2) begin
			creq.load = 1'b1;
			creq.init = (cnt_q == 8'd2);
			creq.data = tail_q[15:8];
		end else if (st_q == S_BYTE && !crcphase_q) begin
			creq.load = 1'b1;
			creq.init = (ridx_q == 6'd0);
			creq.data = nb;
		end
	end

	integer i;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; id_q <= 8'd1; cnt_q <= '0; tail_q <= '0;
			for (i = 0; i < HDR_LEN; i++) hdr_q[i] <= '0;
			clr_q <= '0; ovalid_q <= 1'b0; ridx_q <= '0; qleft_q <= '0;
			addr_q <= '0; lo_q <= 1'b0; crcphase_q <= 1'b0; fcrc_q <= CRC_INIT;
			vword_q <= '0; obyte_q <= '0; olast_q <= 1'b0; ostat_q <= ST_OK;
		end else begin
			if (cfg_valid) id_q <= cfg_data;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 9'd1;
					if (clr_q == 9'(REG_COUNT - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (acc && !is_wr) begin
					tail_q <= {tail_q[7:0], rxb};
					for (i = 0; i < HDR_LEN; i++)
						if (cnt_q == 8'(i)) hdr_q[i] <= rxb;
					if (cnt_q != 8'hFF) cnt_q <= cnt_q + 8'd1;
					st_q <= s_axis_tlast ? S_CRCW : S_WAIT;
				end
				S_WAIT: if (!crsp.busy && !creq.load) st_q <= S_IDLE;
				S_CRCW: if (!crsp.busy) begin
					fcrc_q <= crsp.crc;
					st_q <= S_CHK;
				end
				S_CHK: begin
					cnt_q <= '0; tail_q <= '0;
					for (i = 0; i < HDR_LEN; i++) hdr_q[i] <= '0;
					ridx_q <= '0; lo_q <= 1'b0; crcphase_q <= 1'b0;
					qleft_q <= qty[4:0]; addr_q <= start[8:0];
					obyte_q <= '0; olast_q <= 1'b1;
					priority if (cnt_q < 8'(HDR_LEN)) begin
						ostat_q <= ST_SHORT; ovalid_q <= 1'b1; st_q <= S_OUT;
					end else if ({tail_q[7:0], tail_q[15:8]} != fcrc_q) begin
						ostat_q <= ST_CRC; ovalid_q <= 1'b1; st_q <= S_OUT;
					end else if (hdr_q[0] != 8'd0 && hdr_q[0] != id_q) begin
						ostat_q <= ST_ADDR; ovalid_q <= 1'b1; st_q <= S_OUT;
					end else if (hdr_q[1] != FUNC_READ_INPUT) begin
						ostat_q <= ST_FUNC; ovalid_q <= 1'b1; st_q <= S_OUT;
					end else if (qty == 16'd0 || qty > 16'(MAX_READ)
						|| endp > 17'(REG_COUNT)) begin
						ostat_q <= ST_RANGE; ovalid_q <= 1'b1; st_q <= S_OUT;
					end else begin
						st_q <= S_BYTE;
					end
				end
				S_RD: begin
					// first phase lets the read port register the word at addr_q, second takes it
					if (!crcphase_q) begin
						crcphase_q <= 1'b1;
					end else begin
						crcphase_q <= 1'b0;
						vword_q <= rd_q;
						st_q <= S_BYTE;
					end
				end
				S_BYTE: if (!ovalid_q) begin
					if (!crcphase_q) begin
						obyte_q <= nb; olast_q <= 1'b0; ostat_q <= ST_OK;
						ovalid_q <= 1'b1; crcphase_q <= 1'b1;
					end else if (!crsp.busy) begin
						crcphase_q <= 1'b0;
						ridx_q <= ridx_q + 6'd1;
						if (ridx_q >= 6'd3) begin
							lo_q <= !lo_q;
							if (lo_q) begin
								qleft_q <= qleft_q - 5'd1;
								addr_q <= addr_q + 9'd1;
							end
						end
						if (ridx_q >= 6'd2 && (ridx_q == 6'd2 || lo_q)) begin
							if ((ridx_q == 6'd2 ? qleft_q : qleft_q - 5'd1) == 5'd0) begin
								fcrc_q <= crsp.crc; st_q <= S_OUT; olast_q <= 1'b0;
								lo_q <= 1'b0;
								obyte_q <= 8'h00; ostat_q <= ST_OK;
								ridx_q <= 6'd0;
							end else begin
								st_q <= S_RD;
							end
						end
					end
				end
				S_OUT: if (!ovalid_q) begin
					if (olast_q) begin
						st_q <= S_IDLE; fcrc_q <= CRC_INIT;
					end else if (!lo_q) begin
						obyte_q <= fcrc_q[7:0]; ovalid_q <= 1'b1; lo_q <= 1'b1;
					end else begin
						obyte_q <= fcrc_q[15:8]; ovalid_q <= 1'b1; olast_q <= 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = obyte_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tuser  = ostat_q;
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Modbus RTU read-input-registers slave: a
// directed frame table, then random frames, register writes and noise, all
// checked beat by beat against a behavioral slave model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
	import mbrtu_pkg::*;

	localparam int NREG = 64;
	localparam int NMAX = 29;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [2:0] st;
	} reply_t;

	typedef struct {
		logic        op;
		logic [7:0]  b;
		logic        fend;
		logic [5:0]  idx;
		logic [15:0] val;
		logic        has_exp;
		logic [2:0]  exp_st;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic m_axis_tlast;
	logic [2:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = 8'd1;

	// model state
	logic [7:0]  my_id;
	logic [7:0]  nbytes;
	logic [7:0]  hdr [6];
	logic [15:0] fcrc;
	logic [15:0] tail;
	logic [15:0] bank [NREG];
	logic [2:0]  last_status = 3'd7;

	reply_t reply_q [$];
	int errors = 0;
	int cycles = 0;
	bit hold_rx = 1'b0;
	bit hold_req = 1'b0;
	bit rx_done = 1'b0;
	row_t rows [$];

	modbus_rtu_read_input_slave DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		return r;
	endfunction

	function automatic logic [15:0] crc_of(logic [7:0] bytes [$]);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (bytes[i])
			c = crc_byte(c, bytes[i]);
		return c;
	endfunction

	task automatic clear_frame();
		nbytes = '0;
		foreach (hdr[i])
			hdr[i] = '0;
		fcrc = 16'hFFFF;
		tail = '0;
	endtask

	task automatic push_status(logic [2:0] st);
		reply_q.push_back('{data: 8'h00, last: 1'b1, st: st});
		last_status = st;
	endtask

	// advance the slave model by one accepted input beat
	task automatic slave_step(logic op, logic [7:0] b, logic fend,
			logic [5:0] idx, logic [15:0] val);
		int count, start, qty;
		logic [15:0] rcv, c, crc, v;
		logic [7:0] addr, func;
		last_status = 3'd7;
		if (op == OP_WRITE) begin
			bank[idx] = val;
			return;
		end
		if (nbytes >= 2)
			fcrc = crc_byte(fcrc, tail[15:8]);
		tail = {tail[7:0], b};
		if (nbytes < 6)
			hdr[nbytes] = b;
		if (nbytes < 255)
			nbytes++;
		if (!fend)
			return;
		count = nbytes;
		crc = fcrc;
		rcv = {tail[7:0], tail[15:8]};
		addr = hdr[0];
		func = hdr[1];
		start = {hdr[2], hdr[3]};
		qty = {hdr[4], hdr[5]};
		clear_frame();
		if (count < 6) push_status(ST_SHORT);
		else if (rcv != crc) push_status(ST_CRC);
		else if (addr != 0 && addr != my_id) push_status(ST_ADDR);
		else if (func != FUNC_READ_INPUT) push_status(ST_FUNC);
		else if (qty < 1 || qty > NMAX || start + qty > NREG) push_status(ST_RANGE);
		else begin
			c = 16'hFFFF;
			reply_q.push_back('{my_id, 1'b0, ST_OK});
			c = crc_byte(c, my_id);
			reply_q.push_back('{8'd4, 1'b0, ST_OK});
			c = crc_byte(c, 8'd4);
			reply_q.push_back('{8'(qty * 2), 1'b0, ST_OK});
			c = crc_byte(c, 8'(qty * 2));
			for (int i = 0; i < qty; i++) begin
				v = bank[start + i];
				reply_q.push_back('{v[15:8], 1'b0, ST_OK});
				c = crc_byte(c, v[15:8]);
				reply_q.push_back('{v[7:0], 1'b0, ST_OK});
				c = crc_byte(c, v[7:0]);
			end
			reply_q.push_back('{c[7:0], 1'b0, ST_OK});
			reply_q.push_back('{c[15:8], 1'b1, ST_OK});
		end
	endtask

	// receiver: random stall pattern, or a long hold-off on request
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (reply_q.size() == 0) begin
					$error("reply beat with nothing expected: data %h st %0d",
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					reply_t e;
					e = reply_q.pop_front();
					if (m_axis_tdata !== e.data) begin
						$error("tx_byte: expected %h, got %h", e.data, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== e.last) begin
						$error("tx_last: expected %0d, got %0d", e.last, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, m_axis_tuser);
						errors++;
					end
				end
			end
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 15) == 0)
					stall = (cycles / 5000) % 3 == 0 ? 0 : $urandom_range(1, 40);
			end
		end
	end

	// long hold-off, counted here while the sender keeps offering
	initial begin
		wait (hold_req);
		hold_rx = 1'b1;
		repeat (600) @(posedge clk);
		hold_rx = 1'b0;
	end

	int burst = 0;

	task automatic send(logic op, logic [7:0] b, logic fend, logic [5:0] idx,
			logic [15:0] val);
		int gap;
		if (burst == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst = $urandom_range(1, 12);
		end
		burst--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tlast <= fend;
		s_axis_tdata <= {2'b00, val, idx, b};
		do @(posedge clk); while (!s_axis_tready);
		slave_step(op, b, fend, idx, val);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst = 0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_id(logic [7:0] id);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= id;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		my_id = id;
	endtask

	// send whole frame with random register writes between bytes; optionally corrupt CRC
	task automatic send_frame(logic [7:0] body [$], bit bad_crc);
		logic [15:0] c;
		logic [7:0] f [$];
		c = crc_of(body);
		if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
		f = body;
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
		foreach (f[i]) begin
			if ($urandom_range(0, 9) == 0)
				send(OP_WRITE, 8'($urandom), 1'b0, 6'($urandom), 16'($urandom));
			send(OP_RX_BYTE, f[i], i == f.size() - 1, 6'($urandom), 16'($urandom));
		end
	endtask

	task automatic add_frame(logic [7:0] f [$], logic [2:0] st, bit has);
		foreach (f[i])
			rows.push_back('{OP_RX_BYTE, f[i], i == f.size() - 1, 6'd0, 16'd0,
				has && i == f.size() - 1, st});
	endtask

	// walk the table; rows with a typed-in status are held against the model
	task automatic run_rows();
		foreach (rows[i]) begin
			send(rows[i].op, rows[i].b, rows[i].fend, rows[i].idx, rows[i].val);
			if (rows[i].has_exp && last_status !== rows[i].exp_st) begin
				$error("status: expected %0d, got %0d", rows[i].exp_st, last_status);
				errors++;
			end
		end
		rows.delete();
	endtask

	function automatic logic [7:0] rnd_addr();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return my_id;
		if (r < 8) return 8'd0;
		return 8'($urandom);
	endfunction

	initial begin
		logic [7:0] body [$];
		logic [7:0] f [$];
		logic [15:0] c;
		logic [7:0] ids [4];
		int start, qty;
		my_id = 8'd1;
		clear_frame();
		foreach (bank[i])
			bank[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		rows.push_back('{OP_WRITE, 8'hFF, 1'b1, 6'd0, 16'hFFFF, 1'b0, ST_OK});
		rows.push_back('{OP_WRITE, 8'h00, 1'b0, 6'd63, 16'hA55A, 1'b0, ST_OK});
		rows.push_back('{OP_WRITE, 8'h00, 1'b0, 6'd1, 16'h0000, 1'b0, ST_OK});
		add_frame('{8'h01}, ST_SHORT, 1'b1);
		add_frame('{8'h01, 8'h04, 8'h00, 8'h00, 8'hFF}, ST_SHORT, 1'b1);
		add_frame('{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h01}, ST_CRC, 1'b1);
		body = '{8'h01, 8'h04, 8'h00, 8'h3F, 8'h00, 8'h01}; c = crc_of(body);
		f = body; f.push_back(c[7:0]); f.push_back(c[15:8]);
		add_frame(f, ST_OK, 1'b0);
		body = '{8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h02}; c = crc_of(body);
		f = body; f.push_back(c[7:0]); f.push_back(c[15:8]);
		add_frame(f, ST_OK, 1'b0);
		run_rows();
		drain();

		// more directed frames with typed-in status
		body = '{8'h07, 8'h04, 8'h00, 8'h00, 8'h00, 8'h01}; c = crc_of(body);
		f = body; f.push_back(c[7:0]); f.push_back(c[15:8]);
		add_frame(f, ST_ADDR, 1'b1);
		body = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01}; c = crc_of(body);
		f = body; f.push_back(c[7:0]); f.push_back(c[15:8]);
		add_frame(f, ST_FUNC, 1'b1);
		body = '{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'd30}; c = crc_of(body);
		f = body; f.push_back(c[7:0]); f.push_back(c[15:8]);
		add_frame(f, ST_RANGE, 1'b1);
		body = '{8'h01, 8'h04, 8'h00, 8'd63, 8'h00, 8'd2}; c = crc_of(body);
		f = body; f.push_back(c[7:0]); f.push_back(c[15:8]);
		add_frame(f, ST_RANGE, 1'b1);
		run_rows();
		// full read of 29 registers
		send_frame('{8'h01, 8'h04, 8'h00, 8'd0, 8'h00, 8'd29}, 1'b0);

		// random phases across several ids, extremes included
		ids = '{8'd247, 8'd1, 8'd123, 8'd1};
		for (int p = 0; p < 4; p++) begin
			set_id(ids[p]);
			if (p == 0) hold_req = 1'b1;
			for (int n = 0; n < 8; n++) begin
				int r;
				r = $urandom_range(0, 19);
				if (r < 3) begin
					send(OP_WRITE, 8'($urandom), 1'($urandom), 6'($urandom), 16'($urandom));
				end else if (r < 4) begin
					// noise frame, some long
					qty = $urandom_range(0, 4) == 0 ? $urandom_range(7, 300) : $urandom_range(1, 9);
					for (int i = 0; i < qty; i++)
						send(OP_RX_BYTE, 8'($urandom), i == qty - 1, 6'($urandom), 16'($urandom));
				end else begin
					qty = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(1, 6);
					start = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
						: $urandom_range(0, NREG - qty);
					body = '{rnd_addr(), $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'd4,
						8'(start >> 8), 8'(start), 8'(qty >> 8), 8'(qty)};
					if ($urandom_range(0, 9) == 0)
						body.push_back(8'($urandom));
					send_frame(body, $urandom_range(0, 9) == 0);
				end
				if (p == 1 && n == 4) drain();
			end
		end
		drain();
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

>>> modbus_rtu_read_input_slave.f
design/mbrtu_pkg.sv
design/mbrtu_crc.sv
design/modbus_rtu_read_input_slave.sv
tb/sv/tb.sv
